### rtl/tun_pkg.sv
`timescale 1ns / 1ps

package tun_pkg;

  // fixed widths of the normalized datapath
  localparam int MANT_W      = 31;
  localparam int SQ_W        = 2 * MANT_W;
  localparam int SUM_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int RREM_W      = ROOT_W + 2;
  localparam int ROOT_STAGES = 16;

  // running state of the digit-by-digit square root
  typedef struct packed {
    logic [RREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  rad;
  } root_state_t;

  // one result bit of the square root, two radicand bits consumed
  function automatic root_state_t root_step(root_state_t s);
    logic [RREM_W-1:0] cur;
    logic [RREM_W-1:0] trial;
    root_state_t       r;
    cur   = {s.rem[RREM_W-3:0], s.rad[SUM_W-1:SUM_W-2]};
    trial = {s.root, 2'b01};
    r.rad = s.rad << 2;
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### rtl/tun_div_lane.sv
`timescale 1ns / 1ps

module tun_div_lane #(
  parameter int QUO_W = 15,
  parameter int NUM_W = 46,
  localparam int STAGES = (QUO_W + 1) / 2
) (
  input  logic                        clk,
  input  logic [STAGES-1:0]           en,
  input  logic [NUM_W-1:0]            num,
  input  logic [tun_pkg::ROOT_W-1:0]  len,
  output logic [QUO_W-1:0]            quo
);

  localparam int RW = tun_pkg::ROOT_W;

  logic [RW-1:0]    rem_q [STAGES];
  logic [QUO_W-1:0] low_q [STAGES];
  logic [QUO_W-1:0] quo_q [STAGES];
  logic [RW-1:0]    len_q [STAGES];

  // restoring division, two quotient bits per stage (one in the last stage when QUO_W is odd)
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int STEPS = (2 * s + 1 < QUO_W) ? 2 : 1;
    logic [RW-1:0]    rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [RW-1:0]    len_in;
    logic [RW-1:0]    rem_next;
    logic [QUO_W-1:0] low_next;
    logic [QUO_W-1:0] quo_next;

    if (s == 0) begin : g_first
      assign rem_in = RW'(num[NUM_W-1:QUO_W]);
      assign low_in = num[QUO_W-1:0];
      assign quo_in = '0;
      assign len_in = len;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign len_in = len_q[s-1];
    end

    always_comb begin
      logic [RW:0] trial;
      rem_next = rem_in;
      low_next = low_in;
      quo_next = quo_in;
      for (int t = 0; t < STEPS; t++) begin
        trial = {rem_next, low_next[QUO_W-1]};
        low_next = low_next << 1;
        if (trial >= {1'b0, len_in}) begin
          rem_next = RW'(trial - {1'b0, len_in});
          quo_next = {quo_next[QUO_W-2:0], 1'b1};
        end else begin
          rem_next = trial[RW-1:0];
          quo_next = {quo_next[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_q[s] <= rem_next;
        low_q[s] <= low_next;
        quo_q[s] <= quo_next;
        len_q[s] <= len_in;
      end
    end
  end

  assign quo = quo_q[STAGES-1];

endmodule

### rtl/triangle_unit_normal_top.sv
// pipeline from input beat to result beat: edges, products, cross, magnitude, leading zeros,
// normalize, squares, sum, 16 root stages, divider stages, output register
// throughput: one triangle per cycle while m_axis_tready is high, every stage holds one item and stalls only when full
// reset: rst clears all stage valid bits, payload registers are not reset
`timescale 1ns / 1ps

module triangle_unit_normal_top #(
  parameter int COORD_WIDTH  = 16,
  parameter int NORMAL_WIDTH = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [((3*NORMAL_WIDTH+7)/8)*8-1:0]           m_axis_tdata,
  // degenerate
  output logic                                          m_axis_tuser
);

  localparam int CW      = COORD_WIDTH;
  localparam int NW      = NORMAL_WIDTH;
  localparam int FRAC    = NW - 2;
  localparam int EW      = CW + 1;
  localparam int PRW     = 2 * EW;
  localparam int MW      = PRW - 1;
  localparam int MB      = tun_pkg::MANT_W;
  localparam int PW      = (MW > MB) ? MW : MB;
  localparam int LZW     = $clog2(PW + 1);
  localparam int QB      = FRAC + 1;
  localparam int NUMW    = MB + FRAC + 1;
  localparam int DVS     = (QB + 1) / 2;
  localparam int RS      = tun_pkg::ROOT_STAGES;
  localparam int ST_ROOT = 8;
  localparam int ST_DIV  = ST_ROOT + RS;
  localparam int ST_OUT  = ST_DIV + DVS;
  localparam int NS      = ST_OUT + 1;
  localparam int OUT_W   = ((3 * NW + 7) / 8) * 8;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // stage advance: a stage loads when empty or when its successor loads
  always_comb begin
    en[NS-1] = !vld[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? s_axis_tvalid : vld[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // stage 0: edge vectors
  logic signed [CW-1:0] vin [9];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      vin[i] = s_axis_tdata[i*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EW'(vin[3+i]) - EW'(vin[i]);
        e2[i] <= EW'(vin[6+i]) - EW'(vin[i]);
      end
    end
  end

  // stage 1: six products
  logic signed [PRW-1:0] prod [6];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod[0] <= e1[1] * e2[2];
      prod[1] <= e1[2] * e2[1];
      prod[2] <= e1[2] * e2[0];
      prod[3] <= e1[0] * e2[2];
      prod[4] <= e1[0] * e2[1];
      prod[5] <= e1[1] * e2[0];
    end
  end

  // stage 2: cross product
  logic signed [PRW-1:0] crs [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        crs[i] <= prod[2*i] - prod[2*i+1];
      end
    end
  end

  // stage 3: sign and magnitude
  logic [MW-1:0] mag3 [3];
  logic [2:0]    sgn3;
  logic          deg3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        sgn3[i] <= crs[i][PRW-1];
        mag3[i] <= crs[i][PRW-1] ? MW'(-crs[i]) : MW'(crs[i]);
      end
      deg3 <= (crs[0] == '0) && (crs[1] == '0) && (crs[2] == '0);
    end
  end

  // stage 4: leading zeros of the largest magnitude
  logic [PW-1:0]  or_mag;
  logic [LZW-1:0] lz_d;
  logic [MW-1:0]  mag4 [3];
  logic [2:0]     sgn4;
  logic           deg4;
  logic [LZW-1:0] lz4;

  always_comb begin
    or_mag = PW'(mag3[0] | mag3[1] | mag3[2]);
    lz_d   = LZW'(PW);
    for (int b = 0; b < PW; b++) begin
      if (or_mag[b]) begin
        lz_d = LZW'(PW - 1 - b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mag4 <= mag3;
      sgn4 <= sgn3;
      deg4 <= deg3;
      lz4  <= lz_d;
    end
  end

  // stage 5: common shift to a 31-bit mantissa
  logic [PW-1:0] norm [3];
  logic [MB-1:0] m5 [3];
  logic [2:0]    sgn5;
  logic          deg5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      norm[i] = PW'(mag4[i]) << lz4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        m5[i] <= norm[i][PW-1 -: MB];
      end
      sgn5 <= sgn4;
      deg5 <= deg4;
    end
  end

  // stage 6: squares
  logic [tun_pkg::SQ_W-1:0] sq6 [3];
  logic [MB-1:0]            m6 [3];
  logic [2:0]               sgn6;
  logic                     deg6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= m5[i] * m5[i];
      end
      m6   <= m5;
      sgn6 <= sgn5;
      deg6 <= deg5;
    end
  end

  // stage 7: sum of squares
  logic [tun_pkg::SUM_W-1:0] sum7;
  logic [MB-1:0]             m7 [3];
  logic [2:0]                sgn7;
  logic                      deg7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      sum7 <= tun_pkg::SUM_W'(sq6[0]) + tun_pkg::SUM_W'(sq6[1])
            + tun_pkg::SUM_W'(sq6[2]);
      m7   <= m6;
      sgn7 <= sgn6;
      deg7 <= deg6;
    end
  end

  // square root stages, two result bits each
  tun_pkg::root_state_t rst_q [RS];
  logic [MB-1:0]        rm [RS][3];
  logic [2:0]           rsgn [RS];
  logic [RS-1:0]        rdeg;

  for (genvar k = 0; k < RS; k++) begin : g_root
    tun_pkg::root_state_t st_in;
    logic [MB-1:0]        m_in [3];
    logic [2:0]           sgn_in;
    logic                 deg_in;

    if (k == 0) begin : g_first
      assign st_in.rem  = '0;
      assign st_in.root = '0;
      assign st_in.rad  = sum7;
      assign m_in       = m7;
      assign sgn_in     = sgn7;
      assign deg_in     = deg7;
    end else begin : g_rest
      assign st_in  = rst_q[k-1];
      assign m_in   = rm[k-1];
      assign sgn_in = rsgn[k-1];
      assign deg_in = rdeg[k-1];
    end

    always_ff @(posedge clk) begin
      if (en[ST_ROOT+k]) begin
        rst_q[k] <= tun_pkg::root_step(tun_pkg::root_step(st_in));
        rm[k]    <= m_in;
        rsgn[k]  <= sgn_in;
        rdeg[k]  <= deg_in;
      end
    end
  end

  // rounded quotients: (m * 2^F + len / 2) / len
  logic [tun_pkg::ROOT_W-1:0] len_w;
  logic [NUMW-1:0]            num [3];
  logic [QB-1:0]              quo [3];

  assign len_w = rst_q[RS-1].root;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign num[i] = (NUMW'(rm[RS-1][i]) << FRAC) + NUMW'(len_w >> 1);

    tun_div_lane #(
      .QUO_W (QB),
      .NUM_W (NUMW)
    ) u_div (
      .clk (clk),
      .en  (en[ST_DIV +: DVS]),
      .num (num[i]),
      .len (len_w),
      .quo (quo[i])
    );
  end

  // sign and flag travel beside the divider
  logic [2:0]     dsgn [DVS];
  logic [DVS-1:0] ddeg;

  for (genvar s = 0; s < DVS; s++) begin : g_dside
    always_ff @(posedge clk) begin
      if (en[ST_DIV+s]) begin
        dsgn[s] <= (s == 0) ? rsgn[RS-1] : dsgn[(s == 0) ? 0 : s-1];
        ddeg[s] <= (s == 0) ? rdeg[RS-1] : ddeg[(s == 0) ? 0 : s-1];
      end
    end
  end

  // output register
  logic [NW-1:0] nrm [3];
  logic          deg_o;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      for (int i = 0; i < 3; i++) begin
        if (ddeg[DVS-1]) begin
          nrm[i] <= '0;
        end else if (dsgn[DVS-1][i]) begin
          nrm[i] <= NW'(-NW'(quo[i]));
        end else begin
          nrm[i] <= NW'(quo[i]);
        end
      end
      deg_o <= ddeg[DVS-1];
    end
  end

  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tdata  = OUT_W'({nrm[2], nrm[1], nrm[0]});
  assign m_axis_tuser  = deg_o;

`ifndef SYNTH
  // a degenerate beat carries the zero vector
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3*NW-1:0] == '0)
    else $error("degenerate result with nonzero normal");

  // a unit normal is never the zero vector
  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[3*NW-1:0] != '0)
    else $error("nondegenerate result is zero");

  // a full pipeline under backpressure takes no new beat
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !m_axis_tready |-> !s_axis_tready)
    else $error("beat accepted into a full pipeline");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CW = 16;
  localparam int NW = 16;
  localparam int IN_W = ((9*CW+7)/8)*8;
  localparam int OUT_W = ((3*NW+7)/8)*8;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [NW-1:0] nz;
    logic          degen;
  } face_normal_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  face_normal_t pending_normals[$];
  int  tri_sent = 0;
  int  normals_seen = 0;
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  stall_request = 0;

  triangle_unit_normal_top #(.COORD_WIDTH(CW), .NORMAL_WIDTH(NW)) u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // unit normal of the face spanned by the three vertices
  function automatic face_normal_t face_normal(logic [IN_W-1:0] d);
    logic signed [CW+1:0] e1[3];
    logic signed [CW+1:0] e2[3];
    logic signed [69:0]   cr[3];
    logic [69:0]          mg[3];
    logic [63:0]          mant[3];
    logic [63:0]          sumsq, root, rad, bitv, q;
    logic [NW-1:0]        comp[3];
    face_normal_t         r;
    int                   top;
    for (int i = 0; i < 3; i++) begin
      e1[i] = $signed(d[CW*(3+i) +: CW]) - $signed(d[CW*i +: CW]);
      e2[i] = $signed(d[CW*(6+i) +: CW]) - $signed(d[CW*i +: CW]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    top = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = cr[i][69] ? -cr[i] : cr[i];
      for (int b = 0; b < 70; b++)
        if (mg[i][b] && b + 1 > top) top = b + 1;
    end
    if (top == 0) begin
      r = '0;
      r.degen = 1'b1;
      return r;
    end
    // block normalize so the largest magnitude has bit 30 set
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      mant[i] = (top > 31) ? 64'(mg[i] >> (top - 31)) : 64'(mg[i] << (31 - top));
      sumsq += mant[i] * mant[i];
    end
    // integer square root, two bits per step
    root = 0;
    rad = sumsq;
    bitv = 64'd1 << 62;
    while (bitv > rad) bitv >>= 2;
    while (bitv != 0) begin
      if (rad >= root + bitv) begin
        rad -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    // round to nearest, ties away from zero
    for (int i = 0; i < 3; i++) begin
      q = ((mant[i] << (NW - 2)) + (root >> 1)) / root;
      if (cr[i][69]) q = -q;
      comp[i] = q[NW-1:0];
    end
    r.nx = comp[0];
    r.ny = comp[1];
    r.nz = comp[2];
    r.degen = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [NW-1:0] got,
                                 input logic [NW-1:0] want);
    errors++;
    $display("mismatch %0s at normal %0d: got %0d want %0d", what, normals_seen,
             $signed(got), $signed(want));
  endtask

  // input monitor and result checker
  always @(posedge clk) begin
    face_normal_t exp_n;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      pending_normals.push_back(face_normal(s_axis_tdata));
      tri_sent++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_normals.size() == 0) begin
        errors++;
        $display("unexpected normal beat %h", m_axis_tdata);
      end else begin
        exp_n = pending_normals.pop_front();
        if (m_axis_tdata[NW-1:0] !== exp_n.nx)
          report_mismatch("x", m_axis_tdata[NW-1:0], exp_n.nx);
        if (m_axis_tdata[2*NW-1:NW] !== exp_n.ny)
          report_mismatch("y", m_axis_tdata[2*NW-1:NW], exp_n.ny);
        if (m_axis_tdata[3*NW-1:2*NW] !== exp_n.nz)
          report_mismatch("z", m_axis_tdata[3*NW-1:2*NW], exp_n.nz);
        if (m_axis_tuser !== exp_n.degen)
          report_mismatch("degenerate", NW'(m_axis_tuser), NW'(exp_n.degen));
      end
      normals_seen++;
    end
  end

  // output ready, with random idling and long hold-offs
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        hold = stall_request;
        stall_request = 0;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one triangle beat, called at a falling edge
  task automatic send_triangle(input logic [IN_W-1:0] d);
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    n = tri_sent;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(negedge clk);
    while (tri_sent == n) @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] pack_tri(input int c[9]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[CW*i +: CW] = c[i][CW-1:0];
    return d;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    int t[9];
    int mx, mn;
    mx = 32767;
    mn = -32768;
    t = '{0, 0, 0, 0, 0, 0, 0, 0, 0};             send_triangle(pack_tri(t));
    t = '{5, 5, 5, 5, 5, 5, 5, 5, 5};             send_triangle(pack_tri(t));
    t = '{0, 0, 0, 256, 256, 256, 512, 512, 512}; send_triangle(pack_tri(t));
    t = '{0, 0, 0, 256, 0, 0, 0, 256, 0};         send_triangle(pack_tri(t));
    t = '{0, 0, 0, 0, 256, 0, 256, 0, 0};         send_triangle(pack_tri(t));
    t = '{0, 0, 0, 0, 256, 0, 0, 0, 256};         send_triangle(pack_tri(t));
    t = '{0, 0, 0, 0, 0, 256, 256, 0, 0};         send_triangle(pack_tri(t));
    t = '{0, 0, 0, 1, 0, 0, 0, 1, 0};             send_triangle(pack_tri(t));
    t = '{0, 0, 0, 1, 1, 0, 0, 1, 1};             send_triangle(pack_tri(t));
    t = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};    send_triangle(pack_tri(t));
    t = '{mn, mn, mn, mx, mx, mn, mn, mx, mx};    send_triangle(pack_tri(t));
    t = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};    send_triangle(pack_tri(t));
    t = '{mn, mx, mn, mx, mn, mx, mn, mn, mx};    send_triangle(pack_tri(t));
    t = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};    send_triangle(pack_tri(t));
    t = '{mn, mn, mn, mx, mx, mx, mn, mn, mn};    send_triangle(pack_tri(t));
    t = '{mn, 0, mx, mx, mn, 0, 0, mx, mn};       send_triangle(pack_tri(t));
    t = '{-1, -1, -1, 0, -1, -1, -1, 0, -1};      send_triangle(pack_tri(t));
    t = '{0, 0, 0, 3, 4, 0, -4, 3, 0};            send_triangle(pack_tri(t));
    t = '{10, 20, 30, 11, 20, 30, 10, 21, 31};    send_triangle(pack_tri(t));
    t = '{0, 0, 0, 1000, 1, 0, 0, 1, 1000};       send_triangle(pack_tri(t));
    wait_drained();
  endtask

  // full-range faces, some small, some degenerate
  function automatic logic [IN_W-1:0] random_triangle();
    logic [IN_W-1:0] d;
    int kind, span;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) d[CW*i +: CW] = CW'($urandom);
    if (kind < 3) begin
      span = (kind == 0) ? 4 : 300;
      for (int i = 3; i < 9; i++)
        d[CW*i +: CW] = CW'(d[CW*(i%3) +: CW] + $urandom_range(2*span) - span);
    end else if (kind == 3) begin
      d[CW*3 +: 3*CW] = d[0 +: 3*CW];
    end else if (kind == 4) begin
      // v2 on the line through v0 and v1
      for (int i = 0; i < 3; i++) begin
        d[CW*i +: CW] = CW'($urandom_range(2000) - 1000);
        d[CW*(3+i) +: CW] = CW'(d[CW*i +: CW] + $urandom_range(200) - 100);
        d[CW*(6+i) +: CW] = CW'(2 * d[CW*(3+i) +: CW] - d[CW*i +: CW]);
      end
    end
    return d;
  endfunction

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_triangle(random_triangle());
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 200;
    repeat (80) send_triangle(random_triangle());
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(230, 26, 83);
    test_random(230, 83, 26);
    test_random(160, 0, 0);
    test_backpressure();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
rtl/tun_pkg.sv
rtl/tun_div_lane.sv
rtl/triangle_unit_normal_top.sv
dv/tb_top.sv
